// File: rtl/pcih_pkg.sv
// Package: shared constants, codes and types of the charge integrator histogram.
`timescale 1ns / 1ps
`default_nettype none
package pcih_pkg;

    // Histogram geometry
    localparam int NUM_BINS   = 40;
    localparam int SLOT_COUNT = NUM_BINS + 2;
    localparam int SLOT_W     = 6;
    localparam int RAM_AW     = $clog2(SLOT_COUNT);
    // quotient bits of the bin index (index stays below NUM_BINS)
    localparam int QBITS      = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int STEP_W     = $clog2(QBITS + 1);

    // Field widths
    localparam int SMP_W  = 12;
    localparam int WLEN_W = 16;
    localparam int SUM_W  = 28;
    localparam int CNT_W  = 32;
    localparam int CFG_W  = 28;
    localparam int CFG_AW = 2;

    // Register indexes
    localparam logic [CFG_AW-1:0] REG_PEDESTAL  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_WINDOW    = 2'd1;
    localparam logic [CFG_AW-1:0] REG_HIST_MIN  = 2'd2;
    localparam logic [CFG_AW-1:0] REG_BIN_WIDTH = 2'd3;

    // Register reset values
    localparam logic [SMP_W-1:0]  PEDESTAL_RST  = 12'd2020;
    localparam logic [WLEN_W-1:0] WINDOW_RST    = 16'd2520;
    localparam logic [SUM_W-1:0]  HIST_MIN_RST  = 28'd200000;
    localparam logic [SUM_W-1:0]  BIN_WIDTH_RST = 28'd2500;

    // Saturation limits
    localparam logic [SUM_W-1:0] SUM_MAX   = '1;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Input operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Result kinds
    localparam logic KIND_WINDOW = 1'b0;
    localparam logic KIND_SLOT   = 1'b1;

    // Special slots
    localparam logic [SLOT_W-1:0] SLOT_UNDER = '0;
    localparam logic [SLOT_W-1:0] SLOT_OVER  = SLOT_W'(NUM_BINS + 1);

    // Binner result
    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] slot;
    } bin_res_t;

endpackage
`default_nettype wire

// File: rtl/pulse_charge_integrator_histogram.sv
// Top level: pedestal-subtracted window integrator with a saturating histogram.
`timescale 1ns / 1ps
`default_nettype none
// Each sample beat (tuser = 0) adds |sample - pedestal| into a 28-bit saturating
// accumulator; after window_length samples the window sum is sent out
// (tuser = 0) together with the histogram slot it fell in and that slot's new
// count. A read beat (tuser = 1) returns the count of one slot (0 for slots past
// the overflow slot). The input is ready only while idle, so a read or a closing
// sample is finished before the next beat is taken. A read goes through the
// histogram RAM read, then the output register. For a closing sample the bin
// index is found by a restoring divider that yields one quotient bit a cycle,
// followed by a read-modify-write of the histogram RAM. A sum below hist_min or
// past the last bin, or a zero bin width, skips the divider. A stalled output
// adds its wait to reads and closing samples. The histogram reads as zero right
// after reset, with no clearing pass. Configuration writes belong to idle periods.
module pulse_charge_integrator_histogram (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration write port
    input  wire logic                         cfg_wr_en,
    input  wire logic [pcih_pkg::CFG_AW-1:0]  cfg_addr,
    input  wire logic [pcih_pkg::CFG_W-1:0]   cfg_wdata,
    // input stream
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [23:0]                  s_axis_tdata,  // sample[11:0], bin_select[17:12]
    input  wire logic                         s_axis_tuser,  // op
    // output stream
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic      [71:0]                  m_axis_tdata,  // window_sum, bin_slot, bin_count
    output logic                              m_axis_tuser   // result_kind
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_BIN  = 4'b0100,
        ST_UPD  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [pcih_pkg::SMP_W-1:0]  pedestal_reg;
    logic [pcih_pkg::WLEN_W-1:0] window_reg;
    logic [pcih_pkg::SUM_W-1:0]  hist_min_reg;
    logic [pcih_pkg::SUM_W-1:0]  bin_width_reg;

    // integrator state
    logic [pcih_pkg::SUM_W-1:0]  acc_reg, acc_next;
    logic [pcih_pkg::WLEN_W-1:0] cnt_reg, cnt_next;
    logic [pcih_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [pcih_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic                        range_reg, range_next;
    logic [pcih_pkg::SLOT_COUNT-1:0] valid_reg, valid_next;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic                        out_kind_reg, out_kind_next;
    logic [pcih_pkg::SUM_W-1:0]  out_sum_reg, out_sum_next;
    logic [pcih_pkg::SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [pcih_pkg::CNT_W-1:0]  out_count_reg, out_count_next;

    // beat decode
    logic                        in_op;
    logic [pcih_pkg::SMP_W-1:0]  in_sample;
    logic [pcih_pkg::SLOT_W-1:0] in_sel;
    logic                        accept;
    logic                        out_free;
    logic [pcih_pkg::SMP_W-1:0]  diff;
    logic [pcih_pkg::SUM_W:0]    acc_wide;
    logic [pcih_pkg::SUM_W-1:0]  acc_sat;
    logic [pcih_pkg::WLEN_W-1:0] cnt_inc;
    logic                        win_end;
    logic                        bin_start;

    // RAM and binner hookup
    logic                        ram_we;
    logic                        ram_re;
    logic [pcih_pkg::RAM_AW-1:0] ram_raddr;
    logic [pcih_pkg::CNT_W-1:0]  ram_rdata;
    logic [pcih_pkg::CNT_W-1:0]  cur_count;
    logic [pcih_pkg::CNT_W-1:0]  new_count;
    pcih_pkg::bin_res_t          bin_res;

    assign in_op     = s_axis_tuser;
    assign in_sample = s_axis_tdata[11:0];
    assign in_sel    = s_axis_tdata[17:12];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // pedestal subtraction and saturating accumulate
    always_comb
    begin
        diff     = (in_sample >= pedestal_reg) ? (in_sample - pedestal_reg)
                                               : (pedestal_reg - in_sample);
        acc_wide = {1'b0, acc_reg} + (pcih_pkg::SUM_W + 1)'(diff);
        acc_sat  = acc_wide[pcih_pkg::SUM_W] ? pcih_pkg::SUM_MAX
                                             : acc_wide[pcih_pkg::SUM_W-1:0];
        cnt_inc  = cnt_reg + pcih_pkg::WLEN_W'(1);
        win_end  = (cnt_inc == window_reg);
    end

    assign bin_start = accept && (in_op == pcih_pkg::OP_SAMPLE) && win_end;

    // count read back from the RAM; unwritten slots read as zero
    always_comb
    begin
        cur_count = valid_reg[slot_reg] ? ram_rdata : '0;
        new_count = (cur_count == pcih_pkg::COUNT_MAX) ? cur_count
                                                       : cur_count + pcih_pkg::CNT_W'(1);
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        slot_next      = slot_reg;
        range_next     = range_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_kind_next  = out_kind_reg;
        out_sum_next   = out_sum_reg;
        out_slot_next  = out_slot_reg;
        out_count_next = out_count_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = pcih_pkg::RAM_AW'(in_sel);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == pcih_pkg::OP_READ)
                    begin
                        slot_next  = in_sel;
                        range_next = (pcih_pkg::SLOT_W + 1)'(in_sel)
                                     < (pcih_pkg::SLOT_W + 1)'(pcih_pkg::SLOT_COUNT);
                        ram_re     = range_next;
                        ram_raddr  = pcih_pkg::RAM_AW'(in_sel);
                        state_next = ST_READ;
                    end
                    else if (win_end)
                    begin
                        sum_next   = acc_sat;
                        acc_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_BIN;
                    end
                    else
                    begin
                        acc_next = acc_sat;
                        cnt_next = cnt_inc;
                    end
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = pcih_pkg::KIND_SLOT;
                    out_sum_next   = '0;
                    out_slot_next  = slot_reg;
                    out_count_next = range_reg ? cur_count : '0;
                    state_next     = ST_IDLE;
                end
            end
            ST_BIN:
            begin
                if (bin_res.done)
                begin
                    slot_next  = bin_res.slot;
                    ram_re     = 1'b1;
                    ram_raddr  = pcih_pkg::RAM_AW'(bin_res.slot);
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (out_free)
                begin
                    ram_we              = 1'b1;
                    valid_next[slot_reg] = 1'b1;
                    out_valid_next      = 1'b1;
                    out_kind_next       = pcih_pkg::KIND_WINDOW;
                    out_sum_next        = sum_reg;
                    out_slot_next       = slot_reg;
                    out_count_next      = new_count;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pedestal_reg  <= pcih_pkg::PEDESTAL_RST;
            window_reg    <= pcih_pkg::WINDOW_RST;
            hist_min_reg  <= pcih_pkg::HIST_MIN_RST;
            bin_width_reg <= pcih_pkg::BIN_WIDTH_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                pcih_pkg::REG_PEDESTAL:  pedestal_reg  <= cfg_wdata[pcih_pkg::SMP_W-1:0];
                pcih_pkg::REG_WINDOW:    window_reg    <= cfg_wdata[pcih_pkg::WLEN_W-1:0];
                pcih_pkg::REG_HIST_MIN:  hist_min_reg  <= cfg_wdata[pcih_pkg::SUM_W-1:0];
                pcih_pkg::REG_BIN_WIDTH: bin_width_reg <= cfg_wdata[pcih_pkg::SUM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sum_reg       <= sum_next;
        slot_reg      <= slot_next;
        range_reg     <= range_next;
        out_kind_reg  <= out_kind_next;
        out_sum_reg   <= out_sum_next;
        out_slot_reg  <= out_slot_next;
        out_count_reg <= out_count_next;
    end

    // histogram counts
    pcih_ram #(
        .WIDTH (pcih_pkg::CNT_W),
        .DEPTH (pcih_pkg::SLOT_COUNT)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pcih_pkg::RAM_AW'(slot_reg)),
        .wdata (new_count),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // bin index
    pcih_binner u_binner (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (bin_start),
        .sum       (acc_sat),
        .hist_min  (hist_min_reg),
        .bin_width (bin_width_reg),
        .res       (bin_res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {6'd0, out_count_reg, out_slot_reg, out_sum_reg};

endmodule
`default_nettype wire

// File: rtl/pcih_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pcih_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 42
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/pcih_binner.sv
// Bin index unit: maps a window sum to a histogram slot, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pcih_binner (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [pcih_pkg::SUM_W-1:0]  sum,
    input  wire logic [pcih_pkg::SUM_W-1:0]  hist_min,
    input  wire logic [pcih_pkg::SUM_W-1:0]  bin_width,
    output pcih_pkg::bin_res_t               res
);

    localparam int LIM_W = pcih_pkg::SUM_W + pcih_pkg::QBITS;

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [pcih_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [pcih_pkg::SUM_W-1:0]    rem_reg, rem_next;
    logic [pcih_pkg::SUM_W-1:0]    bw_reg, bw_next;
    logic [pcih_pkg::QBITS-1:0]    quo_reg, quo_next;
    logic [pcih_pkg::STEP_W-1:0]   step_reg, step_next;

    logic [pcih_pkg::SUM_W:0]      off;
    logic [LIM_W-1:0]              limit;
    logic [LIM_W-1:0]              shifted;
    logic                          below;
    logic                          over;

    // range checks at start
    always_comb
    begin
        off   = {1'b0, sum} - {1'b0, hist_min};
        below = off[pcih_pkg::SUM_W];
        limit = LIM_W'(bin_width) * LIM_W'(pcih_pkg::NUM_BINS);
        over  = (bin_width == '0) || (LIM_W'(off[pcih_pkg::SUM_W-1:0]) >= limit);
    end

    // restoring division step
    always_comb
    begin
        shifted    = LIM_W'(bw_reg) << step_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        slot_next  = slot_reg;
        rem_next   = rem_reg;
        bw_next    = bw_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        if (start)
        begin
            if (below)
            begin
                done_next = 1'b1;
                slot_next = pcih_pkg::SLOT_UNDER;
            end
            else if (over)
            begin
                done_next = 1'b1;
                slot_next = pcih_pkg::SLOT_OVER;
            end
            else
            begin
                busy_next = 1'b1;
                rem_next  = off[pcih_pkg::SUM_W-1:0];
                bw_next   = bin_width;
                quo_next  = '0;
                step_next = pcih_pkg::STEP_W'(pcih_pkg::QBITS - 1);
            end
        end
        else if (busy_reg)
        begin
            if (LIM_W'(rem_reg) >= shifted)
            begin
                rem_next = rem_reg - shifted[pcih_pkg::SUM_W-1:0];
                quo_next = quo_reg | (pcih_pkg::QBITS'(1) << step_reg);
            end
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                slot_next = pcih_pkg::SLOT_W'(quo_next) + pcih_pkg::SLOT_W'(1);
            end
            else
            begin
                step_next = step_reg - pcih_pkg::STEP_W'(1);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        rem_reg  <= rem_next;
        bw_reg   <= bw_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
    end

    assign res.done = done_reg;
    assign res.slot = slot_reg;

endmodule
`default_nettype wire
